// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define BSE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/bse_pkg.sv =====
package bse_pkg;

  localparam int Depth = 8;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DataW = 32;
  localparam int OpW   = 3;
  localparam int DistW = 3;

  typedef enum logic [OpW-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_CHANGE  = 3'd3,
    OP_DISPLAY = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_BADINDEX  = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] data;
    logic [CntW-1:0]         count;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== src/bse_ram.sv =====
module bse_ram #(
  parameter int DW = 32,
  parameter int DEPTH_P = 8,
  parameter int AW = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH_P];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bse_ctrl.sv =====
`include "assert_macros.svh"

module bse_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bse_pkg::OpW-1:0]             operation_i,
  input  logic signed [bse_pkg::DataW-1:0]    value_i,
  input  logic [bse_pkg::DistW-1:0]           distance_i,
  input  logic                                out_free_i,
  input  logic [bse_pkg::DataW-1:0]           rdata_i,
  output bse_pkg::mem_req_t                   mem_o,
  output logic                                res_load_o,
  output bse_pkg::res_t                       res_o
);

  import bse_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] k_q, k_d;
  status_e         status_q, status_d;
  logic            use_data_q, use_data_d;
  logic            disp_q, disp_d;
  logic            accept;
  logic            last;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign last       = !disp_q || ((k_q + CntW'(1)) == fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      k_q        <= '0;
      status_q   <= STAT_OK;
      use_data_q <= 1'b0;
      disp_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      k_q        <= k_d;
      status_q   <= status_d;
      use_data_q <= use_data_d;
      disp_q     <= disp_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    k_d        = k_q;
    status_d   = status_q;
    use_data_d = use_data_q;
    disp_d     = disp_q;
    mem_o      = '0;
    mem_o.wdata = value_i;
    res_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d    = ST_RESP;
          status_d   = STAT_OK;
          use_data_d = 1'b0;
          disp_d     = 1'b0;
          k_d        = '0;
          unique case (operation_i)
            OP_PUSH: begin
              if (fill_q == CntW'(Depth)) begin
                status_d = STAT_OVERFLOW;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = AddrW'(fill_q);
                fill_d      = fill_q + CntW'(1);
              end
            end
            OP_POP: begin
              if (fill_q == '0) begin
                status_d = STAT_UNDERFLOW;
              end else begin
                mem_o.re    = 1'b1;
                mem_o.raddr = AddrW'(fill_q - CntW'(1));
                fill_d      = fill_q - CntW'(1);
                use_data_d  = 1'b1;
              end
            end
            OP_PEEK, OP_CHANGE: begin
              if (fill_q == '0) begin
                status_d = STAT_UNDERFLOW;
              end else if (32'(distance_i) >= 32'(fill_q)) begin
                status_d = STAT_BADINDEX;
              end else if (operation_i == OP_PEEK) begin
                mem_o.re    = 1'b1;
                mem_o.raddr = AddrW'(fill_q) - AddrW'(1) - AddrW'(distance_i);
                use_data_d  = 1'b1;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = AddrW'(fill_q) - AddrW'(1) - AddrW'(distance_i);
              end
            end
            OP_DISPLAY: begin
              if (fill_q == '0) begin
                status_d = STAT_UNDERFLOW;
              end else begin
                mem_o.re    = 1'b1;
                mem_o.raddr = AddrW'(fill_q - CntW'(1));
                use_data_d  = 1'b1;
                disp_d      = 1'b1;
              end
            end
            default: begin
              status_d = STAT_BADINDEX;
            end
          endcase
        end
      end
      ST_RESP: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            // fetch the next entry down while this one goes out
            mem_o.re    = 1'b1;
            mem_o.raddr = AddrW'(fill_q) - AddrW'(k_q) - AddrW'(2);
            k_d         = k_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.status = status_q;
    res_o.data   = use_data_q ? rdata_i : '0;
    res_o.count  = fill_q;
    res_o.last   = last;
  end

  `BSE_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= CntW'(Depth), "fill level above depth")
  `BSE_ASSERT_NEVER(a_one_port, clk_i, rst_ni, mem_o.we && mem_o.re, "read and write together")
  `BSE_ASSERT(a_full_push, clk_i, rst_ni,
    (accept && operation_i == OP_PUSH && fill_q == CntW'(Depth)) |=> $stable(fill_q),
    "push on full stack changed fill level")
  `BSE_ASSERT(a_disp_walk, clk_i, rst_ni,
    (state_q == ST_RESP && disp_q) |-> (k_q < fill_q), "display walked past fill level")

endmodule

// ===== src/bounded_stack_engine.sv =====
// bounded LIFO stack of Depth signed 32-bit words (push, pop, peek, change, display).
// push, pop, peek and change issue the memory access when taken in ST_IDLE; ST_RESP
// then captures the read word into the output register once it is free. display
// gives one result per held entry (one underflow result when empty), and each read
// of the next entry is issued as the previous result is loaded, paced by the single
// read port of the stack memory and its registered read data. a finished result
// waits in the output register while the next request is taken.
module bounded_stack_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bse_pkg::OpW-1:0]          operation_i,
  input  logic signed [bse_pkg::DataW-1:0] value_i,
  input  logic [bse_pkg::DistW-1:0]        distance_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [bse_pkg::DataW-1:0] data_o,
  output logic [bse_pkg::CntW-1:0]         count_o,
  output logic                             last_o
);

  import bse_pkg::*;

  mem_req_t         mem_req;
  logic [DataW-1:0] rdata;
  logic             res_load;
  res_t             res;
  res_t             res_q;
  logic             out_valid_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  bse_ram #(
    .DW      (DataW),
    .DEPTH_P (Depth),
    .AW      (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  bse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .distance_i  (distance_i),
    .out_free_i  (out_free),
    .rdata_i     (rdata),
    .mem_o       (mem_req),
    .res_load_o  (res_load),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign data_o      = res_q.data;
  assign count_o     = res_q.count;
  assign last_o      = res_q.last;

endmodule

// ===== sim/tb_bounded_stack_engine.sv =====
module tb_bounded_stack_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import bse_pkg::*;

  localparam logic [OpW-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int unsigned    CYCLE_LIMIT    = 200000;
  localparam int unsigned    RANDOM_ITEMS   = 80;

  class stack_scoreboard;
    logic signed [DataW-1:0] words [Depth];
    int unsigned             fill;
    res_t                    pending [$];
    int unsigned             errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void add_result(status_e st, logic signed [DataW-1:0] d, logic fin);
      res_t r;
      r.status = st;
      r.data   = d;
      r.count  = CntW'(fill);
      r.last   = fin;
      pending.push_back(r);
    endfunction

    // work out the transfers one accepted request causes
    function void note_request(logic [OpW-1:0] op, logic signed [DataW-1:0] val,
                               logic [DistW-1:0] dist_sel);
      int unsigned slot;
      case (op)
        OP_PUSH: begin
          if (fill >= Depth) begin
            add_result(STAT_OVERFLOW, '0, 1'b1);
          end else begin
            words[fill] = val;
            fill++;
            add_result(STAT_OK, '0, 1'b1);
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            add_result(STAT_UNDERFLOW, '0, 1'b1);
          end else begin
            fill--;
            add_result(STAT_OK, words[fill], 1'b1);
          end
        end
        OP_PEEK, OP_CHANGE: begin
          if (fill == 0) begin
            add_result(STAT_UNDERFLOW, '0, 1'b1);
          end else if (dist_sel >= fill) begin
            add_result(STAT_BADINDEX, '0, 1'b1);
          end else begin
            slot = fill - 1 - dist_sel;
            if (op == OP_PEEK) begin
              add_result(STAT_OK, words[slot], 1'b1);
            end else begin
              words[slot] = val;
              add_result(STAT_OK, '0, 1'b1);
            end
          end
        end
        OP_DISPLAY: begin
          if (fill == 0) begin
            add_result(STAT_UNDERFLOW, '0, 1'b1);
          end else begin
            for (int unsigned k = 0; k < fill; k++) begin
              add_result(STAT_OK, words[fill - 1 - k], k + 1 == fill);
            end
          end
        end
        default: begin
          add_result(STAT_BADINDEX, '0, 1'b1);
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic signed [DataW-1:0] d,
                      logic [CntW-1:0] cnt, logic fin);
      res_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected transfer status %0d data %0d count %0d last %0b",
                         st, d, cnt, fin));
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        report($sformatf("status %0d, want %0d", st, want.status));
      end
      if (d !== want.data) begin
        report($sformatf("data %0d, want %0d", d, want.data));
      end
      if (cnt !== want.count) begin
        report($sformatf("count %0d, want %0d", cnt, want.count));
      end
      if (fin !== want.last) begin
        report($sformatf("last %0b, want %0b", fin, want.last));
      end
    endtask
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [OpW-1:0]          operation_i = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic [DistW-1:0]        distance_i  = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              status_o;
  logic signed [DataW-1:0] data_o;
  logic [CntW-1:0]         count_o;
  logic                    last_o;

  stack_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     stall_mode  = 0;

  bounded_stack_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .distance_i  (distance_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(status_o, data_o, count_o, last_o);
    end
    if (cycle_count % 50 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      2:       out_stall_i <= (cycle_count % 7 < 3);
      default: out_stall_i <= ($urandom_range(0, 2) != 0);
    endcase
  end

  task automatic drive_request(logic [OpW-1:0] op, logic signed [DataW-1:0] val,
                               logic [DistW-1:0] dist_sel);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    distance_i  <= dist_sel;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, val, dist_sel);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic directed_traffic();
    logic signed [DataW-1:0] seeds [8];
    seeds = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1,
              32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0001, 32'sh1234_5678};
    // empty stack corner cases
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      drive_request(OpW'(op), 32'sh0f0f_0f0f, 3'd0);
    end
    drive_request(OP_POP, '0, 3'd0);
    drive_request(OP_PEEK, '0, 3'd0);
    drive_request(OP_CHANGE, 32'sh7fff_ffff, 3'd0);
    drive_request(OP_DISPLAY, '0, 3'd0);
    // fill to the top, then one push too many
    foreach (seeds[i]) begin
      drive_request(OP_PUSH, seeds[i], 3'd0);
    end
    drive_request(OP_PUSH, 32'sh3333_3333, 3'd0);
    drive_request(OP_PEEK, '0, 3'd7);
    drive_request(OP_CHANGE, 32'sh8000_0000, 3'd0);
    drive_request(OP_DISPLAY, '0, 3'd0);
    drive_request(OP_POP, '0, 3'd0);
    // distance past the fill level, then change and peek the bottom entry
    drive_request(OP_PEEK, '0, 3'd7);
    drive_request(OP_CHANGE, -32'sd2, 3'd6);
    drive_request(OP_PEEK, '0, 3'd6);
    drive_request(OP_DISPLAY, '0, 3'd0);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned             burst;
    int unsigned             gap;
    int unsigned             pick;
    int unsigned             push_pct;
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] v;
    logic [DistW-1:0]        dist_sel;
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 16);
      end
      push_pct = (sb.fill <= 1) ? 55 : (sb.fill >= 7) ? 20 : 35;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        op = OpW'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end else if (pick < 4 + push_pct) begin
        op = OP_PUSH;
      end else begin
        case ($urandom_range(0, 3))
          0:       op = OP_POP;
          1:       op = OP_PEEK;
          2:       op = OP_CHANGE;
          default: op = OP_DISPLAY;
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2:       v = '0;
          default: v = -32'sd1;
        endcase
      end else begin
        v = $urandom;
      end
      if (sb.fill > 0 && $urandom_range(0, 4) != 0) begin
        dist_sel = DistW'($urandom_range(0, sb.fill - 1));
      end else begin
        dist_sel = DistW'($urandom_range(0, 7));
      end
      drive_request(op, v, dist_sel);
      burst--;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_traffic();
    wait_drained();
    random_traffic(RANDOM_ITEMS / 2);
    wait_drained();
    random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      sb.report("results still outstanding");
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
